/* hw/rtl/emfp_pkg.sv */
// shared types and constants of the energy meter frame parser
`default_nettype none
package emfp_pkg;

  localparam int FRAME_BYTES = 24;
  localparam int POS_W       = 5;
  localparam int BYTE_W      = 8;
  localparam int COEF_W      = 24;
  localparam int GAIN_W      = 10;
  localparam int FLOOR_W     = 16;
  localparam int QUOT_W      = 34;
  localparam int WATT_W      = 24;
  localparam int PULSE_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int STEP_W      = 6;

  localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(FRAME_BYTES - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUOT_W - 1);

  // header bytes
  localparam logic [BYTE_W-1:0] HDR_NORMAL = 8'h55;
  localparam logic [BYTE_W-1:0] HDR_ALT    = 8'hF2;
  localparam logic [BYTE_W-1:0] HDR_SYNC   = 8'h5A;

  // header status masks
  localparam logic [BYTE_W-1:0] MASK_ABNORMAL = 8'hFC;
  localparam logic [BYTE_W-1:0] MASK_VFAULT   = 8'hF8;
  localparam logic [BYTE_W-1:0] MASK_AFAULT   = 8'hF4;
  localparam logic [BYTE_W-1:0] MASK_PFAULT   = 8'hF2;
  localparam logic [BYTE_W-1:0] ADJ_POWER_EN  = 8'h10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_FLOOR = 2'd2;

  localparam logic [GAIN_W-1:0]  RST_VOLTAGE_GAIN  = 10'd10;
  localparam logic [GAIN_W-1:0]  RST_CURRENT_GAIN  = 10'd1000;
  localparam logic [FLOOR_W-1:0] RST_CURRENT_FLOOR = 16'd100;

  // reading selected for the shared divider
  localparam logic [1:0] OP_VOLT = 2'd0;
  localparam logic [1:0] OP_AMP  = 2'd1;
  localparam logic [1:0] OP_WATT = 2'd2;

  typedef struct packed {
    logic       take;   // input word accepted
    logic       load;   // load numerator and divisor for op
    logic       step;   // one restoring divide step
    logic       store;  // write quotient into the reading for op
    logic       push;   // move readings into the output register
    logic [1:0] op;
  } emfp_cmd_t;

  typedef struct packed {
    logic frame_end;  // next word completes a frame
    logic abnormal;   // stored header flags abnormal hardware
  } emfp_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/emfp_datapath.sv */
// frame store, multiplier, shared serial divider and reading registers
`default_nettype none
module emfp_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire emfp_pkg::emfp_cmd_t                  cmd,
  output emfp_pkg::emfp_stat_t                      stat,
  input  wire logic [emfp_pkg::BYTE_W-1:0]          rx_byte,
  input  wire logic                                 relay_on,
  input  wire logic [emfp_pkg::GAIN_W-1:0]          voltage_gain,
  input  wire logic [emfp_pkg::GAIN_W-1:0]          current_gain,
  input  wire logic [emfp_pkg::FLOOR_W-1:0]         current_floor,
  output logic      [emfp_pkg::QUOT_W-1:0]          volts,
  output logic      [emfp_pkg::QUOT_W-1:0]          amps,
  output logic      [emfp_pkg::WATT_W-1:0]          watts,
  output logic      [emfp_pkg::PULSE_W-1:0]         pulse_count
);

  logic [emfp_pkg::BYTE_W-1:0] frame_r [emfp_pkg::FRAME_BYTES];
  logic [emfp_pkg::POS_W-1:0]  pos_r;
  logic [emfp_pkg::BYTE_W-1:0] last_r;
  logic                        relay_r;

  logic [emfp_pkg::QUOT_W-1:0] quot_r;
  logic [emfp_pkg::COEF_W-1:0] rem_r;
  logic [emfp_pkg::COEF_W-1:0] dvs_r;

  logic [emfp_pkg::QUOT_W-1:0] volts_r;
  logic [emfp_pkg::QUOT_W-1:0] amps_r;
  logic [emfp_pkg::WATT_W-1:0] watts_r;

  logic                        hdr_hit;
  logic [emfp_pkg::BYTE_W-1:0] hdr;
  logic [emfp_pkg::COEF_W-1:0] coef_sel;
  logic [emfp_pkg::COEF_W-1:0] cycle_sel;
  logic [emfp_pkg::GAIN_W-1:0] gain_sel;
  logic [emfp_pkg::QUOT_W-1:0] product;
  logic [emfp_pkg::COEF_W:0]   rem_sh;
  logic [emfp_pkg::COEF_W:0]   rem_sub;
  logic                        dvs_zero;
  logic [emfp_pkg::QUOT_W-1:0] amps_raw;

  assign hdr     = frame_r[0];
  assign hdr_hit = (last_r == emfp_pkg::HDR_NORMAL || last_r == emfp_pkg::HDR_ALT)
                   && rx_byte == emfp_pkg::HDR_SYNC;

  assign stat.frame_end = (pos_r == emfp_pkg::LAST_POS);
  assign stat.abnormal  = (hdr & emfp_pkg::MASK_ABNORMAL) == emfp_pkg::MASK_ABNORMAL;

  // frame capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      last_r  <= '0;
      relay_r <= 1'b0;
    end else if (cmd.take) begin
      last_r <= rx_byte;
      if (pos_r == '0) begin
        if (hdr_hit) begin
          pos_r <= emfp_pkg::POS_W'(2);
        end
      end else if (pos_r == emfp_pkg::LAST_POS) begin
        pos_r   <= '0;
        relay_r <= relay_on;
      end else begin
        pos_r <= pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      if (pos_r == '0) begin
        if (hdr_hit) begin
          frame_r[0] <= last_r;
          frame_r[1] <= rx_byte;
        end
      end else begin
        frame_r[pos_r] <= rx_byte;
      end
    end
  end

  // operand selection, big-endian fields of the frame
  always_comb begin
    case (cmd.op)
      emfp_pkg::OP_VOLT: begin
        coef_sel  = {frame_r[2], frame_r[3], frame_r[4]};
        cycle_sel = {frame_r[5], frame_r[6], frame_r[7]};
        gain_sel  = voltage_gain;
      end
      emfp_pkg::OP_AMP: begin
        coef_sel  = {frame_r[8], frame_r[9], frame_r[10]};
        cycle_sel = {frame_r[11], frame_r[12], frame_r[13]};
        gain_sel  = current_gain;
      end
      default: begin
        coef_sel  = {frame_r[14], frame_r[15], frame_r[16]};
        cycle_sel = {frame_r[17], frame_r[18], frame_r[19]};
        gain_sel  = emfp_pkg::GAIN_W'(1);
      end
    endcase
  end

  assign product = emfp_pkg::QUOT_W'(coef_sel) * emfp_pkg::QUOT_W'(gain_sel);

  // restoring division, one quotient bit a cycle
  assign rem_sh  = {rem_r, quot_r[emfp_pkg::QUOT_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quot_r <= product;
      rem_r  <= '0;
      dvs_r  <= cycle_sel;
    end else if (cmd.step) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_r  <= rem_sub[emfp_pkg::COEF_W-1:0];
        quot_r <= {quot_r[emfp_pkg::QUOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh[emfp_pkg::COEF_W-1:0];
        quot_r <= {quot_r[emfp_pkg::QUOT_W-2:0], 1'b0};
      end
    end
  end

  assign dvs_zero = (dvs_r == '0);
  assign amps_raw = (!relay_r || dvs_zero ||
                     (hdr & emfp_pkg::MASK_AFAULT) == emfp_pkg::MASK_AFAULT) ? '0 : quot_r;

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      case (cmd.op)
        emfp_pkg::OP_VOLT: begin
          if (!relay_r || dvs_zero ||
              (hdr & emfp_pkg::MASK_VFAULT) == emfp_pkg::MASK_VFAULT) begin
            volts_r <= '0;
          end else begin
            volts_r <= quot_r;
          end
        end
        emfp_pkg::OP_AMP: begin
          if (amps_raw < emfp_pkg::QUOT_W'(current_floor)) begin
            amps_r <= '0;
          end else begin
            amps_r <= amps_raw;
          end
        end
        default: begin
          if (!relay_r || dvs_zero ||
              (frame_r[20] & emfp_pkg::ADJ_POWER_EN) == '0 ||
              (hdr & emfp_pkg::MASK_PFAULT) == emfp_pkg::MASK_PFAULT) begin
            watts_r <= '0;
          end else begin
            watts_r <= quot_r[emfp_pkg::WATT_W-1:0];
          end
        end
      endcase
    end
  end

  assign volts       = volts_r;
  assign amps        = amps_r;
  assign watts       = watts_r;
  assign pulse_count = {frame_r[21], frame_r[22]};

endmodule
`default_nettype wire

/* hw/rtl/emfp_ctrl.sv */
// controller: byte intake, divider sequencing and result hand-off
`default_nettype none
module emfp_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 out_full,
  input  wire logic                 out_ready,
  input  wire emfp_pkg::emfp_stat_t stat,
  output emfp_pkg::emfp_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_STORE = 3'd3;
  localparam logic [2:0] S_PUSH  = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  logic [1:0]                  op_r, op_nxt;
  logic [emfp_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic                        in_fire;
  logic                        out_space;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_space = !out_full || out_ready;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.op    = op_r;
    cmd.take  = in_fire;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && stat.frame_end && !stat.abnormal) begin
          state_nxt = S_LOAD;
          op_nxt    = emfp_pkg::OP_VOLT;
        end
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == emfp_pkg::LAST_STEP) begin
          state_nxt = S_STORE;
        end
      end
      S_STORE: begin
        cmd.store = 1'b1;
        if (op_r == emfp_pkg::OP_WATT) begin
          state_nxt = S_PUSH;
        end else begin
          op_nxt    = op_r + 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_PUSH: begin
        if (out_space) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= emfp_pkg::OP_VOLT;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && !in_fire) |=> state_r == S_IDLE)
    else $error("controller left idle without a word");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == emfp_pkg::LAST_STEP) |=> state_r == S_STORE)
    else $error("divide did not end after the last step");

  a_watt_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STORE && op_r == emfp_pkg::OP_WATT) |=> state_r == S_PUSH)
    else $error("power reading stored without hand-off");

endmodule
`default_nettype wire

/* hw/rtl/energy_meter_frame_parser.sv */
// Energy meter frame parser top level: configuration registers and output register.
// Usage: feed received serial bytes on the in_ channel, one word per byte, with the
// relay state alongside. The block hunts for a header (0x55 or 0xF2 then 0x5A), stores
// the 24-byte frame and, at its last byte, decodes voltage, current, power and the CF
// pulse count into one word on the out_ channel; frames flagged abnormal give nothing.
// Throughput: one byte per cycle while a frame is being collected. The byte that ends
// a frame not flagged abnormal starts three divisions on one shared restoring divider,
// each a load, a restoring step for each of the 34 quotient bits and a store, then a
// hand-off into the output register, and in_tready stays low until that hand-off.
// The output register lets byte intake go on while a result waits to be taken; if the
// receiver still stalls when the next frame's result is ready, the block holds that
// result and keeps in_tready low until the output register frees.
// Reset (rst_n low, synchronous) returns to header hunting, empties the output register
// and sets voltage_gain 10, current_gain 1000, current_floor 100.
// Configuration is written through cfg_we/cfg_index/cfg_wdata; the user must do so only
// while the block is idle, as the block itself does not enforce it; index 3 is ignored.
`default_nettype none
module energy_meter_frame_parser (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [15:0]                         in_tdata,   // rx_byte, relay_on
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [111:0]                        out_tdata,  // volts, amps, watts, pulse_count
  input  wire logic                                cfg_we,
  input  wire logic [emfp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [emfp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [emfp_pkg::GAIN_W-1:0]  vgain_r;
  logic [emfp_pkg::GAIN_W-1:0]  cgain_r;
  logic [emfp_pkg::FLOOR_W-1:0] floor_r;

  logic         out_tvalid_r;
  logic [107:0] out_data_r;

  emfp_pkg::emfp_cmd_t  cmd;
  emfp_pkg::emfp_stat_t stat;

  logic [emfp_pkg::QUOT_W-1:0]  volts;
  logic [emfp_pkg::QUOT_W-1:0]  amps;
  logic [emfp_pkg::WATT_W-1:0]  watts;
  logic [emfp_pkg::PULSE_W-1:0] pulse_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vgain_r <= emfp_pkg::RST_VOLTAGE_GAIN;
      cgain_r <= emfp_pkg::RST_CURRENT_GAIN;
      floor_r <= emfp_pkg::RST_CURRENT_FLOOR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        emfp_pkg::REG_VOLTAGE_GAIN:  vgain_r <= cfg_wdata[emfp_pkg::GAIN_W-1:0];
        emfp_pkg::REG_CURRENT_GAIN:  cgain_r <= cfg_wdata[emfp_pkg::GAIN_W-1:0];
        emfp_pkg::REG_CURRENT_FLOOR: floor_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  emfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_full  (out_tvalid_r),
    .out_ready (out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  emfp_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .rx_byte       (in_tdata[7:0]),
    .relay_on      (in_tdata[8]),
    .voltage_gain  (vgain_r),
    .current_gain  (cgain_r),
    .current_floor (floor_r),
    .volts         (volts),
    .amps          (amps),
    .watts         (watts),
    .pulse_count   (pulse_count)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.push) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data_r <= {pulse_count, watts, amps, volts};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0, out_data_r};

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> out_tvalid)
    else $error("result word not presented after hand-off");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!out_tvalid_r || out_tready))
    else $error("hand-off overwrote a waiting result");

endmodule
`default_nettype wire
